// ----- rtl/conflict_free_block_scheduler_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the conflict-free block scheduler
// ---------------------------------------------------------------------------
`ifndef CONFLICT_FREE_BLOCK_SCHEDULER_UNIT_DEFINES_SVH
`define CONFLICT_FREE_BLOCK_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication
`define CFBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cfbs_pkg.sv -----
// ---------------------------------------------------------------------------
// cfbs_pkg
// Types, codes and helper functions of the conflict-free block scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

package cfbs_pkg;

  localparam int CFBS_MAX_BLOCKS = 64;
  localparam int CFBS_GRID       = 16;
  localparam int CFBS_COUNT_BITS = 16;
  localparam int CFBS_TAG_BITS   = 16;
  localparam int CFBS_POS_BITS   = 4;
  localparam int CFBS_DIM_BITS   = 5;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_GET  = 1'b1;

  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  localparam logic [CFBS_DIM_BITS-1:0] DIM_RESET = CFBS_DIM_BITS'(CFBS_GRID);

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NONE   = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef struct packed {
    logic                       opcode;
    logic [CFBS_POS_BITS-1:0]   block_row;
    logic [CFBS_POS_BITS-1:0]   block_col;
    logic [CFBS_COUNT_BITS-1:0] update_count;
  } in_item_t;

  typedef struct packed {
    status_t                    status;
    logic [CFBS_POS_BITS-1:0]   grant_row;
    logic [CFBS_POS_BITS-1:0]   grant_col;
    logic [CFBS_COUNT_BITS-1:0] grant_count;
  } out_item_t;

  // one stored block
  typedef struct packed {
    logic [CFBS_POS_BITS-1:0]   row;
    logic [CFBS_POS_BITS-1:0]   col;
    logic [CFBS_COUNT_BITS-1:0] count;
    logic [CFBS_TAG_BITS-1:0]   tag;
  } entry_t;

  // Galois LFSR, shift right
  function automatic logic [15:0] lfsr_next(input logic [15:0] cur);
    logic [15:0] sh;
    sh = {1'b0, cur[15:1]};
    return cur[0] ? (sh ^ LFSR_TAPS) : sh;
  endfunction

  function automatic logic [CFBS_COUNT_BITS-1:0] sat_inc(
    input logic [CFBS_COUNT_BITS-1:0] cnt
  );
    return (&cnt) ? cnt : cnt + CFBS_COUNT_BITS'(1);
  endfunction

  // clamp a grid dimension to 1..GRID
  function automatic logic [CFBS_DIM_BITS-1:0] eff_dim(
    input logic [CFBS_DIM_BITS-1:0] v
  );
    logic [CFBS_DIM_BITS-1:0] r;
    r = v;
    if (v == '0) r = CFBS_DIM_BITS'(1);
    else if (v > DIM_RESET) r = DIM_RESET;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cfbs_entry_ram.sv -----
// ---------------------------------------------------------------------------
// cfbs_entry_ram
// Block table storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module cfbs_entry_ram
  import cfbs_pkg::*;
#(
  parameter int DEPTH  = CFBS_MAX_BLOCKS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire entry_t            wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output entry_t                 rdata_r
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/conflict_free_block_scheduler_unit.sv -----
// ---------------------------------------------------------------------------
// conflict_free_block_scheduler_unit
// Hands out grid blocks to workers so that no two running blocks share a row
// or a column; blocks with the fewest updates go first.
// ---------------------------------------------------------------------------
// One transaction at a time: a start is taken while busy is low, and the
// result shows on out_data for exactly one cycle with out_valid high; it must
// be sampled then. A push outside the configured grid answers on the next
// cycle without raising busy. Any other push walks the valid bits one slot a
// cycle for the lowest free slot and stays busy until it writes that slot, or
// until it rejects the push at the last slot when the table is full. A get
// reads every table slot through the single read port of the entry memory,
// one slot a cycle, and stays busy through S_GET, S_DRAIN and S_GRANT. The
// result shows in the first cycle that busy is low again.
// Valid bits and the row/column busy maps are flip-flops cleared by reset, so
// no clearing pass is needed. Write configuration only while busy is low.
// ---------------------------------------------------------------------------
`default_nettype none

module conflict_free_block_scheduler_unit
  import cfbs_pkg::*;
#(
  parameter int MAX_BLOCKS = CFBS_MAX_BLOCKS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire in_item_t                 in_data,
  output logic                          out_valid,
  output out_item_t                     out_data,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [CFBS_DIM_BITS-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PUSH  = 5'b00010,
    S_GET   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_GRANT = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  in_item_t                 req_r, req_nxt;
  logic [MAX_BLOCKS-1:0]    valid_r, valid_nxt;
  logic [CFBS_GRID-1:0]     row_busy_r, row_busy_nxt;
  logic [CFBS_GRID-1:0]     col_busy_r, col_busy_nxt;
  logic [15:0]              lfsr_r, lfsr_nxt;
  logic [CFBS_DIM_BITS-1:0] row_count_r, row_count_nxt;
  logic [CFBS_DIM_BITS-1:0] col_count_r, col_count_nxt;
  logic                     rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic                     best_found_r, best_found_nxt;
  logic [IDX_W-1:0]         best_idx_r, best_idx_nxt;
  entry_t                   best_r, best_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic                     ram_we;
  entry_t                   ram_wdata;
  entry_t                   ram_rdata;
  logic                     outside;
  logic                     cand;
  logic                     better;
  logic [15:0]              lfsr_adv;

  cfbs_entry_ram #(
    .DEPTH  (MAX_BLOCKS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (idx_r),
    .wdata   (ram_wdata),
    .raddr   (idx_r),
    .rdata_r (ram_rdata)
  );

  assign lfsr_adv = lfsr_next(lfsr_r);
  assign outside  = ({1'b0, in_data.block_row} >= eff_dim(row_count_r)) ||
                    ({1'b0, in_data.block_col} >= eff_dim(col_count_r));

  assign ram_wdata.row   = req_r.block_row;
  assign ram_wdata.col   = req_r.block_col;
  assign ram_wdata.count = sat_inc(req_r.update_count);
  assign ram_wdata.tag   = lfsr_adv[CFBS_TAG_BITS-1:0];

  // scan compare on the slot read in the previous cycle
  assign cand   = rd_vld_r && valid_r[rd_idx_r] &&
                  !row_busy_r[ram_rdata.row] && !col_busy_r[ram_rdata.col];
  assign better = !best_found_r || (ram_rdata.count < best_r.count) ||
                  ((ram_rdata.count == best_r.count) && (ram_rdata.tag < best_r.tag));

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    req_nxt        = req_r;
    valid_nxt      = valid_r;
    row_busy_nxt   = row_busy_r;
    col_busy_nxt   = col_busy_r;
    lfsr_nxt       = lfsr_r;
    row_count_nxt  = row_count_r;
    col_count_nxt  = col_count_r;
    rd_vld_nxt     = (state_r == S_GET);
    rd_idx_nxt     = idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_nxt       = best_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = '0;
    ram_we         = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_COUNT: row_count_nxt = cfg_wdata;
        CFG_COL_COUNT: col_count_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (cand && better) begin
      best_found_nxt = 1'b1;
      best_idx_nxt   = rd_idx_r;
      best_nxt       = ram_rdata;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt        = in_data;
          idx_nxt        = '0;
          best_found_nxt = 1'b0;
          if (in_data.opcode == OP_PUSH) begin
            if (outside) begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = ST_REJECT;
            end else begin
              // the worker is done with this row and column either way
              row_busy_nxt[in_data.block_row] = 1'b0;
              col_busy_nxt[in_data.block_col] = 1'b0;
              state_nxt = S_PUSH;
            end
          end else begin
            state_nxt = S_GET;
          end
        end
      end
      S_PUSH: begin
        if (!valid_r[idx_r]) begin
          ram_we              = 1'b1;
          valid_nxt[idx_r]    = 1'b1;
          lfsr_nxt            = lfsr_adv;
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = ST_OK;
          state_nxt           = S_IDLE;
        end else if (idx_r == LAST_IDX) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = ST_REJECT;
          state_nxt           = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_GET: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_GRANT;
      end
      S_GRANT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (best_found_r) begin
          valid_nxt[best_idx_r]     = 1'b0;
          row_busy_nxt[best_r.row]  = 1'b1;
          col_busy_nxt[best_r.col]  = 1'b1;
          out_data_nxt.status       = ST_OK;
          out_data_nxt.grant_row    = best_r.row;
          out_data_nxt.grant_col    = best_r.col;
          out_data_nxt.grant_count  = best_r.count;
        end else begin
          out_data_nxt.status = ST_NONE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      row_busy_r   <= '0;
      col_busy_r   <= '0;
      lfsr_r       <= LFSR_SEED;
      row_count_r  <= DIM_RESET;
      col_count_r  <= DIM_RESET;
      rd_vld_r     <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      row_busy_r   <= row_busy_nxt;
      col_busy_r   <= col_busy_nxt;
      lfsr_r       <= lfsr_nxt;
      row_count_r  <= row_count_nxt;
      col_count_r  <= col_count_nxt;
      rd_vld_r     <= rd_vld_nxt;
      best_found_r <= best_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    req_r      <= req_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/cfbs_checker.sv -----
// ---------------------------------------------------------------------------
// cfbs_checker
// Port-level checks of the block scheduler, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "conflict_free_block_scheduler_unit_defines.svh"

module cfbs_checker
  import cfbs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_item_t out_data
);

  // every accepted transaction either completes at once or holds busy
  `CFBS_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || out_valid,
                    "accepted transaction neither busy nor answered")

  // the end of a busy period always delivers its result
  `CFBS_ASSERT_NOW(a_busy_end_result, clk, rst_n, $fell(busy), out_valid,
                   "busy dropped without a result")

  `CFBS_ASSERT_NOW(a_no_result_while_busy, clk, rst_n, busy, !out_valid,
                   "result strobe while busy")

  // only a successful grant carries block data
  `CFBS_ASSERT_NOW(a_fields_zero, clk, rst_n, out_valid && (out_data.status != ST_OK),
                   (out_data.grant_row == '0) && (out_data.grant_col == '0) && (out_data.grant_count == '0),
                   "grant fields set on a non-ok result")

endmodule

bind conflict_free_block_scheduler_unit cfbs_checker u_cfbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block scheduler testbench
// Drives push and get transactions into the scheduler and predicts every
// answer: the table of waiting blocks, the row/column busy maps and the tag
// generator are tracked here.
// Directed cases come first, then random phases over many grid sizes. The
// random phases mostly push blocks that were granted earlier, the way
// workers do; other pushes are fresh or outside the grid, among gets.
// ----------------------------------------------------------------------------
module tb;
  import cfbs_pkg::*;

  localparam int RUN_LIMIT  = 1000000;
  localparam int PHASES     = 12;
  localparam int PER_PHASE  = 150;
  localparam logic [CFBS_COUNT_BITS-1:0] COUNT_TOP = '1;

  // Predicts the scheduler's answers and checks them in order.
  class grant_scoreboard;
    bit                         used      [CFBS_MAX_BLOCKS];
    logic [CFBS_POS_BITS-1:0]   slot_row  [CFBS_MAX_BLOCKS];
    logic [CFBS_POS_BITS-1:0]   slot_col  [CFBS_MAX_BLOCKS];
    logic [CFBS_COUNT_BITS-1:0] slot_count[CFBS_MAX_BLOCKS];
    logic [CFBS_TAG_BITS-1:0]   slot_tag  [CFBS_MAX_BLOCKS];
    bit                         row_taken [CFBS_GRID];
    bit                         col_taken [CFBS_GRID];
    logic [15:0]                tag_state;
    logic [CFBS_DIM_BITS-1:0]   rows_cfg;
    logic [CFBS_DIM_BITS-1:0]   cols_cfg;
    out_item_t                  owed[$];
    int mismatches, checked, n_granted, n_none, n_reject, n_full;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      foreach (row_taken[i]) begin
        row_taken[i] = 1'b0;
        col_taken[i] = 1'b0;
      end
      tag_state = LFSR_SEED;
      rows_cfg  = CFBS_DIM_BITS'(CFBS_GRID);
      cols_cfg  = CFBS_DIM_BITS'(CFBS_GRID);
    endfunction

    function void set_dim(logic idx, logic [CFBS_DIM_BITS-1:0] v);
      if (idx == CFG_ROW_COUNT) rows_cfg = v;
      else cols_cfg = v;
    endfunction

    // register value as the grid actually uses it
    function int grid_span(logic [CFBS_DIM_BITS-1:0] v);
      if (v == 0) return 1;
      if (v > CFBS_GRID) return CFBS_GRID;
      return int'(v);
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function out_item_t note_request(in_item_t it);
      out_item_t res;
      int slot;
      logic lsb;
      logic [CFBS_COUNT_BITS-1:0] cnt;
      res = '0;
      res.status = ST_OK;
      slot = -1;
      if (it.opcode == OP_PUSH) begin
        if (int'(it.block_row) >= grid_span(rows_cfg) ||
            int'(it.block_col) >= grid_span(cols_cfg)) begin
          res.status = ST_REJECT;
        end else begin
          // the worker is done with row and column even if the block is dropped
          row_taken[it.block_row] = 1'b0;
          col_taken[it.block_col] = 1'b0;
          for (int i = 0; i < CFBS_MAX_BLOCKS && slot < 0; i++)
            if (!used[i]) slot = i;
          if (slot < 0) begin
            res.status = ST_REJECT;
            n_full++;
          end else begin
            cnt = it.update_count;
            if (cnt != COUNT_TOP) cnt = cnt + 1'b1;
            lsb = tag_state[0];
            tag_state = tag_state >> 1;
            if (lsb) tag_state = tag_state ^ LFSR_TAPS;
            used[slot]       = 1'b1;
            slot_row[slot]   = it.block_row;
            slot_col[slot]   = it.block_col;
            slot_count[slot] = cnt;
            slot_tag[slot]   = tag_state[CFBS_TAG_BITS-1:0];
          end
        end
      end else begin
        // fewest updates first, then smallest tag, then lowest slot
        for (int i = 0; i < CFBS_MAX_BLOCKS; i++) begin
          if (used[i] && !row_taken[slot_row[i]] && !col_taken[slot_col[i]]) begin
            if (slot < 0 || slot_count[i] < slot_count[slot] ||
                (slot_count[i] == slot_count[slot] && slot_tag[i] < slot_tag[slot]))
              slot = i;
          end
        end
        if (slot < 0) begin
          res.status = ST_NONE;
        end else begin
          used[slot] = 1'b0;
          row_taken[slot_row[slot]] = 1'b1;
          col_taken[slot_col[slot]] = 1'b1;
          res.grant_row   = slot_row[slot];
          res.grant_col   = slot_col[slot];
          res.grant_count = slot_count[slot];
        end
      end
      owed = {owed, res};
      return res;
    endfunction

    function void check_grant(out_item_t got);
      out_item_t want;
      checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no transaction outstanding: st=%0d r=%0d c=%0d n=%0h",
                   $realtime, got.status, got.grant_row, got.grant_col, got.grant_count);
        return;
      end
      want = owed.pop_front();
      case (got.status)
        ST_OK:   if (want.status == ST_OK && got.grant_count != 0 || want.grant_count != 0)
                   n_granted++;
        ST_NONE: n_none++;
        default: n_reject++;
      endcase
      if (got.status != want.status || got.grant_row != want.grant_row ||
          got.grant_col != want.grant_col || got.grant_count != want.grant_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected st/r/c/n %0d/%0d/%0d/%0h, got %0d/%0d/%0d/%0h",
                   $realtime, want.status, want.grant_row, want.grant_col, want.grant_count,
                   got.status, got.grant_row, got.grant_col, got.grant_count);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  in_item_t                 in_data;
  logic                     out_valid;
  out_item_t                out_data;
  logic                     cfg_we;
  logic                     cfg_index;
  logic [CFBS_DIM_BITS-1:0] cfg_wdata;

  grant_scoreboard sb;
  in_item_t        on_loan[$];   // blocks granted and not yet returned
  bit              start_high;
  int              calm_left;
  int              cycles;
  int              settings_seen;

  conflict_free_block_scheduler_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d transactions outstanding", cycles, sb.pending());
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_grant(out_data);
  end

  function automatic in_item_t mk(logic op, int r, int c, int n);
    in_item_t it;
    it.opcode       = op;
    it.block_row    = CFBS_POS_BITS'(r);
    it.block_col    = CFBS_POS_BITS'(c);
    it.update_count = CFBS_COUNT_BITS'(n);
    return it;
  endfunction

  // Offers one transaction and returns at the edge that accepts it; start is
  // left high so a back-to-back transaction needs no extra assignment.
  task automatic send_item(input in_item_t it);
    int gap;
    out_item_t res;
    in_item_t back;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(10, 40);
      gap = $urandom_range(0, 8);
    end
    if (gap > 0) begin
      if (start_high) start <= 1'b0;
      start_high = 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    start_high = 1'b1;
    do @(posedge clk); while (busy);
    res = sb.note_request(it);
    if (it.opcode == OP_GET && res.status == ST_OK) begin
      back = mk(OP_PUSH, res.grant_row, res.grant_col, res.grant_count);
      on_loan = {on_loan, back};
    end
  endtask

  // hold off until every outstanding transaction has answered
  task automatic drain();
    if (start_high) start <= 1'b0;
    start_high = 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_dims(input logic [CFBS_DIM_BITS-1:0] r,
                            input logic [CFBS_DIM_BITS-1:0] c);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_wdata <= r;
    @(posedge clk);
    sb.set_dim(CFG_ROW_COUNT, r);
    cfg_index <= CFG_COL_COUNT;
    cfg_wdata <= c;
    @(posedge clk);
    sb.set_dim(CFG_COL_COUNT, c);
    cfg_we <= 1'b0;
    settings_seen++;
  endtask

  function automatic logic [CFBS_DIM_BITS-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFBS_DIM_BITS'(1);
      2:       return CFBS_DIM_BITS'(2);
      3:       return CFBS_DIM_BITS'(CFBS_GRID);
      4:       return '1;
      5:       return CFBS_DIM_BITS'(CFBS_GRID - 1);
      default: return CFBS_DIM_BITS'($urandom_range(0, 31));
    endcase
  endfunction

  // Mostly returns a granted block with its count; otherwise a fresh block.
  function automatic in_item_t pick_push();
    in_item_t it;
    int k, n, r, c;
    if (on_loan.size() > 0 && $urandom_range(0, 99) < 60) begin
      k = $urandom_range(0, on_loan.size() - 1);
      it = on_loan[k];
      on_loan.delete(k);
      return it;
    end
    case ($urandom_range(0, 19))
      0, 1, 2:  n = $urandom_range(65533, 65535);
      3, 4, 5, 6, 7, 8: n = $urandom_range(0, 65535);
      default:  n = $urandom_range(0, 3);
    endcase
    if ($urandom_range(0, 11) == 0) begin
      // anywhere in the 16x16 space, often off the configured grid
      r = $urandom_range(0, 15);
      c = $urandom_range(0, 15);
    end else begin
      r = $urandom_range(0, sb.grid_span(sb.rows_cfg) - 1);
      c = $urandom_range(0, sb.grid_span(sb.cols_cfg) - 1);
    end
    return mk(OP_PUSH, r, c, n);
  endfunction

  initial begin
    in_item_t it;
    int push_pct;
    sb = new();
    start_high = 1'b0;
    calm_left = 0;
    cycles = 0;
    settings_seen = 1;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_ROW_COUNT;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: full 16x16 grid from reset
    send_item(mk(OP_GET, 0, 0, 0));           // empty table
    send_item(mk(OP_PUSH, 0, 0, 0));
    send_item(mk(OP_PUSH, 15, 15, 65535));    // already saturated
    send_item(mk(OP_PUSH, 3, 5, 65534));      // saturates on increment
    send_item(mk(OP_GET, 0, 0, 0));           // lowest count wins
    send_item(mk(OP_PUSH, 0, 7, 0));          // frees row 0 again
    send_item(mk(OP_GET, 15, 15, 65535));
    send_item(mk(OP_GET, 0, 0, 0));           // equal counts, tag decides
    send_item(mk(OP_GET, 0, 0, 0));
    send_item(mk(OP_GET, 0, 0, 0));           // empty again
    // 1x1 grid: zero clamps up to one
    write_dims('0, '0);
    send_item(mk(OP_PUSH, 0, 0, 5));
    send_item(mk(OP_PUSH, 0, 0, 16'hAAAA));
    send_item(mk(OP_PUSH, 0, 1, 0));          // column off the grid
    send_item(mk(OP_PUSH, 1, 0, 0));          // row off the grid
    send_item(mk(OP_GET, 0, 0, 0));
    send_item(mk(OP_GET, 0, 0, 0));           // block waiting, row busy
    send_item(mk(OP_PUSH, 0, 0, 16'h5555));
    send_item(mk(OP_GET, 0, 0, 0));
    // oversized values clamp to the full grid
    write_dims('1, CFBS_DIM_BITS'(3));
    send_item(mk(OP_PUSH, 15, 2, 16'h00FF));
    send_item(mk(OP_PUSH, 15, 3, 0));
    send_item(mk(OP_GET, 15, 15, 65535));
    on_loan.delete();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       write_dims(CFBS_DIM_BITS'(CFBS_GRID), CFBS_DIM_BITS'(CFBS_GRID));
        1:       write_dims(CFBS_DIM_BITS'(1), CFBS_DIM_BITS'(CFBS_GRID));
        2:       write_dims('1, CFBS_DIM_BITS'(1));
        3:       write_dims(CFBS_DIM_BITS'(2), CFBS_DIM_BITS'(2));
        default: write_dims(pick_dim(), pick_dim());
      endcase
      case ($urandom_range(0, 2))
        0:       push_pct = 50;
        1:       push_pct = 65;
        default: push_pct = 85;   // fills the table
      endcase
      for (int k = 0; k < PER_PHASE; k++) begin
        if ($urandom_range(0, 99) < push_pct) it = pick_push();
        else it = mk(OP_GET, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 65535));
        send_item(it);
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    repeat (2 * CFBS_MAX_BLOCKS) @(posedge clk);
    $display("%0d transactions checked over %0d grid settings: %0d grants, %0d none free,",
             sb.checked, settings_seen, sb.n_granted, sb.n_none);
    $display("%0d pushes rejected (%0d on a full table), %0d mismatches",
             sb.n_reject, sb.n_full, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
